FILE: hdl/homopeptide_run_counter_core_macros.svh
// Assertion macros used by the checker file.
`ifndef HOMOPEPTIDE_RUN_COUNTER_CORE_MACROS_SVH
`define HOMOPEPTIDE_RUN_COUNTER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HRC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define HRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/hrc_pkg.sv
`default_nettype none

package hrc_pkg;

   localparam int MAX_SEQ_LEN = 8192;
   localparam int ALPHA_SIZE  = 21;
   localparam int IDX_W       = 5;
   localparam int CNT_W       = 14;
   localparam int BYTE_W      = 8;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 64;
   localparam int FIELD_MAX   = 16383;
   localparam int CAP_INT     = (MAX_SEQ_LEN < FIELD_MAX) ? MAX_SEQ_LEN : FIELD_MAX;

   localparam logic [CNT_W-1:0]  SAT_CAP      = CNT_W'(CAP_INT);
   localparam logic [IDX_W-1:0]  IDX_NONE     = '1;
   localparam logic [IDX_W-1:0]  IDX_LAST     = IDX_W'(ALPHA_SIZE - 1);
   localparam logic [IDX_W-1:0]  EMIT_LAST    = IDX_W'(ALPHA_SIZE);
   localparam logic [BYTE_W-1:0] THR_RESET    = 8'd3;
   localparam logic [BYTE_W-1:0] THR_MIN      = 8'd2;
   localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'd32;
   localparam logic [BYTE_W-1:0] LOWER_FIRST  = 8'h61;
   localparam logic [BYTE_W-1:0] LOWER_LAST   = 8'h7a;

   typedef enum logic {
      KIND_SUMMARY = 1'b0,
      KIND_RESIDUE = 1'b1
   } hrc_kind_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
      logic             eos;
   } hrc_item_type;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] total;
      logic [CNT_W-1:0] shortest;
      logic [CNT_W-1:0] clean;
      logic [CNT_W-1:0] count_rd;
   } hrc_tract_status_type;

   typedef struct packed {
      logic             busy;
      logic [IDX_W-1:0] rd_idx;
      logic             clear;
   } hrc_emit_ctrl_type;

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      begin
         s = {1'b0, a} + {1'b0, b};
         sat_add = (s > {1'b0, SAT_CAP}) ? SAT_CAP : s[CNT_W-1:0];
      end
   endfunction

   function automatic logic [IDX_W-1:0] letter_index(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] u;
      begin
         u = (b >= LOWER_FIRST && b <= LOWER_LAST) ? b - CASE_OFFSET : b;
         unique case (u)
            "A":     letter_index = 5'd0;
            "C":     letter_index = 5'd1;
            "D":     letter_index = 5'd2;
            "E":     letter_index = 5'd3;
            "F":     letter_index = 5'd4;
            "G":     letter_index = 5'd5;
            "H":     letter_index = 5'd6;
            "I":     letter_index = 5'd7;
            "K":     letter_index = 5'd8;
            "L":     letter_index = 5'd9;
            "M":     letter_index = 5'd10;
            "N":     letter_index = 5'd11;
            "P":     letter_index = 5'd12;
            "Q":     letter_index = 5'd13;
            "R":     letter_index = 5'd14;
            "S":     letter_index = 5'd15;
            "T":     letter_index = 5'd16;
            "V":     letter_index = 5'd17;
            "W":     letter_index = 5'd18;
            "X":     letter_index = 5'd19;
            "Y":     letter_index = 5'd20;
            default: letter_index = IDX_NONE;
         endcase
      end
   endfunction

endpackage

`default_nettype wire

FILE: hdl/homopeptide_run_counter_core.sv
// Homopeptide tract counter. Takes one sequence byte per cycle on req_, folds
// lower case, drops bytes outside ACDEFGHIKLMNPQRSTVWXY and follows runs of one
// residue; a run of at least csr_wdata's threshold (reset 3, values below 2 act
// as 2) counts as a tract. The word with req_tlast closes the sequence; after the
// decoder registers it, the output serializer sends 22 words on rsp_: one
// summary (rsp_tuser 0) and one per residue in alphabet order (rsp_tuser 1), the
// last with rsp_tlast. Ordinary bytes go at one per cycle; from the final byte
// until the last result word is loaded req_tready stays low. The serializer reads
// one residue counter per cycle while rsp_tready is high or its output is empty.
// Counts saturate at 8192. Write the threshold only while idle.
`default_nettype none

module homopeptide_run_counter_core
   import hrc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [BYTE_W-1:0]     csr_wdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] residue_byte
   input  wire logic                  req_tlast,   // end_of_sequence
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [4:0] residue_index,
                                                   // [18:5] residue_tract_count,
                                                   // [32:19] total_tract_residues,
                                                   // [46:33] shortest_tract,
                                                   // [60:47] clean_length, [63:61] zero
   output logic                       rsp_tuser,   // result_kind
   output logic                       rsp_tlast    // last_result
);

   hrc_item_type         item;
   hrc_tract_status_type status;
   hrc_emit_ctrl_type    ctrl;

   hrc_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .busy       (ctrl.busy),
      .item       (item)
   );

   hrc_tract u_tract (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .item      (item),
      .ctrl      (ctrl),
      .status    (status)
   );

   hrc_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .status     (status),
      .ctrl       (ctrl),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

FILE: hdl/hrc_decode.sv
`default_nettype none

module hrc_decode
   import hrc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tlast,
   input  wire logic                  busy,
   output hrc_item_type               item
);

   logic             valid_ff, valid_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             eos_ff, eos_in;

   // hold off while a final word waits here or results are going out
   assign req_tready = !busy && !(valid_ff && eos_ff);

   always_comb begin
      valid_in = req_tvalid && req_tready;
      idx_in   = letter_index(req_tdata[BYTE_W-1:0]);
      eos_in   = req_tlast;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      idx_ff <= idx_in;
      eos_ff <= eos_in;
   end

   assign item = '{valid: valid_ff, idx: idx_ff, eos: eos_ff};

endmodule

`default_nettype wire

FILE: hdl/hrc_tract.sv
`default_nettype none

module hrc_tract
   import hrc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [BYTE_W-1:0] csr_wdata,
   input  wire hrc_item_type      item,
   input  wire hrc_emit_ctrl_type ctrl,
   output hrc_tract_status_type   status
);

   logic [BYTE_W-1:0] threshold_ff;
   logic              prev_valid_ff, prev_valid_in;
   logic [IDX_W-1:0]  prev_ff, prev_in;
   logic [CNT_W-1:0]  run_ff, run_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [CNT_W-1:0]  shortest_ff, shortest_in;
   logic [CNT_W-1:0]  clean_ff, clean_in;
   logic [CNT_W-1:0]  counts_ff [ALPHA_SIZE];

   logic [BYTE_W-1:0] thr;
   logic              is_letter;
   logic              same;
   logic [CNT_W-1:0]  run_inc;
   logic              close_do;
   logic [CNT_W-1:0]  close_len;
   logic              close_hit;
   logic [IDX_W-1:0]  rd_addr;
   logic [CNT_W-1:0]  count_rd;
   logic [CNT_W-1:0]  count_new;

   always_comb begin
      thr       = (threshold_ff < THR_MIN) ? THR_MIN : threshold_ff;
      is_letter = item.idx != IDX_NONE;
      same      = is_letter && prev_valid_ff && (prev_ff == item.idx);
      run_inc   = sat_add(run_ff, CNT_W'(1));
      rd_addr   = ctrl.busy ? ctrl.rd_idx : prev_ff;
      count_rd  = counts_ff[rd_addr];

      // one run closes per word at most: a fresh run of one never reaches the threshold
      if (same) begin
         close_do  = item.eos;
         close_len = run_inc;
      end else begin
         close_do  = is_letter || item.eos;
         close_len = run_ff;
      end
      close_hit = item.valid && close_do && prev_valid_ff && (close_len >= CNT_W'(thr));
      count_new = sat_add(count_rd, close_len);

      prev_valid_in = prev_valid_ff;
      prev_in       = prev_ff;
      run_in        = run_ff;
      total_in      = total_ff;
      shortest_in   = shortest_ff;
      clean_in      = clean_ff;

      if (item.valid) begin
         if (is_letter) begin
            prev_valid_in = 1'b1;
            prev_in       = item.idx;
            run_in        = same ? run_inc : CNT_W'(1);
            clean_in      = sat_add(clean_ff, CNT_W'(1));
         end
         if (item.eos) begin
            run_in = '0;
         end
         if (close_hit) begin
            total_in = sat_add(total_ff, close_len);
            if (shortest_ff == '0 || close_len < shortest_ff) begin
               shortest_in = close_len;
            end
         end
      end

      if (ctrl.clear) begin
         prev_valid_in = 1'b0;
         prev_in       = '0;
         run_in        = '0;
         total_in      = '0;
         shortest_in   = '0;
         clean_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= THR_RESET;
         prev_valid_ff <= 1'b0;
         prev_ff       <= '0;
         run_ff        <= '0;
         total_ff      <= '0;
         shortest_ff   <= '0;
         clean_ff      <= '0;
      end else begin
         if (csr_we) begin
            threshold_ff <= csr_wdata;
         end
         prev_valid_ff <= prev_valid_in;
         prev_ff       <= prev_in;
         run_ff        <= run_in;
         total_ff      <= total_in;
         shortest_ff   <= shortest_in;
         clean_ff      <= clean_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         for (int k = 0; k < ALPHA_SIZE; k++) begin
            counts_ff[k] <= '0;
         end
      end else if (close_hit) begin
         counts_ff[prev_ff] <= count_new;
      end
   end

   assign status = '{start:    item.valid && item.eos,
                     total:    total_ff,
                     shortest: shortest_ff,
                     clean:    clean_ff,
                     count_rd: count_rd};

endmodule

`default_nettype wire

FILE: hdl/hrc_emit.sv
`default_nettype none

module hrc_emit
   import hrc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire hrc_tract_status_type status,
   output hrc_emit_ctrl_type         ctrl,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [RSP_DATA_W-1:0]     rsp_tdata,
   output logic                      rsp_tuser,
   output logic                      rsp_tlast
);

   logic                  busy_ff, busy_in;
   logic [IDX_W-1:0]      cnt_ff, cnt_in;
   logic                  valid_ff, valid_in;
   hrc_kind_type          kind_ff, kind_in;
   logic [RSP_DATA_W-1:0] data_ff, data_in;
   logic                  last_ff, last_in;

   logic                  load;
   logic                  done;
   logic [IDX_W-1:0]      rd_idx;

   always_comb begin
      load    = busy_ff && (!valid_ff || rsp_tready);
      done    = load && (cnt_ff == EMIT_LAST);
      rd_idx  = (cnt_ff == '0) ? '0 : cnt_ff - IDX_W'(1);

      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff && !rsp_tready;
      kind_in  = kind_ff;
      data_in  = data_ff;
      last_in  = last_ff;

      if (status.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end
      if (load) begin
         valid_in = 1'b1;
         cnt_in   = cnt_ff + IDX_W'(1);
         if (cnt_ff == '0) begin
            kind_in = KIND_SUMMARY;
            data_in = {(RSP_DATA_W - IDX_W - 4 * CNT_W)'(0), status.clean,
                       status.shortest, status.total, CNT_W'(0), IDX_W'(0)};
            last_in = 1'b0;
         end else begin
            kind_in = KIND_RESIDUE;
            data_in = {(RSP_DATA_W - IDX_W - CNT_W)'(0), status.count_rd, rd_idx};
            last_in = rd_idx == IDX_LAST;
         end
      end
      if (done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
      kind_ff <= kind_in;
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign ctrl       = '{busy: busy_ff, rd_idx: rd_idx, clear: done};
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

FILE: hdl/hrc_port_checker.sv
`default_nettype none
`include "homopeptide_run_counter_core_macros.svh"

module hrc_port_checker
   import hrc_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  csr_we,
   input wire logic [BYTE_W-1:0]     csr_wdata,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic [REQ_DATA_W-1:0] req_tdata,
   input wire logic                  req_tlast,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tuser,
   input wire logic                  rsp_tlast
);

   `HRC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast),
      "stalled result word changed")

   `HRC_ASSERT_IMPLY(a_no_input_mid_burst, clock, reset, rsp_tvalid && !rsp_tlast,
      !req_tready, "input taken while a result burst is open")

   `HRC_ASSERT_IMPLY(a_summary_shape, clock, reset, rsp_tvalid && rsp_tuser == KIND_SUMMARY,
      rsp_tdata[18:0] == 19'd0 && rsp_tdata[63:61] == 3'd0 && !rsp_tlast,
      "summary word carries residue fields or last flag")

   `HRC_ASSERT_IMPLY(a_residue_shape, clock, reset, rsp_tvalid && rsp_tuser == KIND_RESIDUE,
      rsp_tdata[63:19] == 45'd0 && rsp_tdata[4:0] <= 5'd20,
      "residue word carries summary fields or a bad index")

endmodule

bind homopeptide_run_counter_core hrc_port_checker u_port_checker (.*);

`default_nettype wire
